// ===== rtl/qpd_pkg.sv =====
`timescale 1ns / 1ps
// qpd_pkg: shared types, character constants and helpers for the
// quoted-printable byte decoder; used by qpd_decode, qpd_outbuf and the top level
package qpd_pkg;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // most results one input word can cause
    localparam int unsigned MAX_RES = 3;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_EQ    = 2'd1,
        MODE_HEX1  = 2'd2,
        MODE_EQCR  = 2'd3
    } t_mode;

    // results of one input word, handed from decoder to output buffer
    typedef struct packed {
        logic [1:0]                 cnt;
        logic [MAX_RES-1:0][7:0]    data;
        logic                       bare;
        logic                       send;
    } t_burst;

    // hex digit test: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== rtl/qpd_decode.sv =====
`timescale 1ns / 1ps
// qpd_decode: escape state register and the combinational decode of one word
// depends on qpd_pkg
module qpd_decode
    import qpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_mark,
    output t_burst      o_burst
);

    t_mode      r_mode;
    t_mode      n_mode;
    logic [3:0] r_nibble;
    logic [3:0] n_nibble;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_nibble <= 4'd0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_nibble <= n_nibble;
        end
    end

    always_comb begin
        logic [1:0] k;
        logic [4:0] h;
        t_burst     b;
        k        = 2'd0;
        h        = hex_value(i_data_byte);
        b        = '0;
        n_mode   = r_mode;
        n_nibble = r_nibble;

        case (r_mode)
            MODE_PLAIN: begin
                if (i_data_byte == CH_EQ) begin
                    n_mode = MODE_EQ;
                end else begin
                    b.data[k] = i_data_byte;
                    k = k + 2'd1;
                end
            end
            MODE_EQ: begin
                n_mode = MODE_PLAIN;
                if (i_data_byte == CH_LF) begin
                    // soft line break
                end else if (i_data_byte == CH_CR) begin
                    n_mode = MODE_EQCR;
                end else if (i_data_byte == CH_EQ) begin
                    b.data[k] = CH_EQ;
                    k = k + 2'd1;
                end else if (h[4]) begin
                    n_nibble = h[3:0];
                    n_mode   = MODE_HEX1;
                end else begin
                    b.data[k] = CH_EQ;
                    k = k + 2'd1;
                    b.data[k] = i_data_byte;
                    k = k + 2'd1;
                end
            end
            MODE_HEX1: begin
                n_mode = MODE_PLAIN;
                // a non-hex second digit is swallowed, one-digit value sent
                b.data[k] = h[4] ? {r_nibble, h[3:0]} : {4'd0, r_nibble};
                k = k + 2'd1;
                n_nibble = 4'd0;
            end
            MODE_EQCR: begin
                n_mode = MODE_PLAIN;
                if (i_data_byte != CH_LF) begin
                    b.data[k] = CH_EQ;
                    k = k + 2'd1;
                    b.data[k] = CH_CR;
                    k = k + 2'd1;
                    if (i_data_byte == CH_EQ) begin
                        n_mode = MODE_EQ;
                    end else begin
                        b.data[k] = i_data_byte;
                        k = k + 2'd1;
                    end
                end
            end
            default: begin
                n_mode = MODE_PLAIN;
            end
        endcase

        if (i_end_mark) begin
            // flush a pending partial escape
            case (n_mode)
                MODE_EQ: begin
                    b.data[k] = CH_EQ;
                    k = k + 2'd1;
                end
                MODE_HEX1: begin
                    b.data[k] = {4'd0, n_nibble};
                    k = k + 2'd1;
                end
                MODE_EQCR: begin
                    b.data[k] = CH_EQ;
                    k = k + 2'd1;
                    b.data[k] = CH_CR;
                    k = k + 2'd1;
                end
                default: begin
                end
            endcase
            n_mode   = MODE_PLAIN;
            n_nibble = 4'd0;
            b.send   = 1'b1;
            if (k == 2'd0) begin
                b.bare = 1'b1;
                k      = 2'd1;
            end
        end

        b.cnt   = k;
        o_burst = b;
    end

endmodule

// ===== rtl/qpd_outbuf.sv =====
`timescale 1ns / 1ps
// qpd_outbuf: result register holding up to three decoded words, drained one a cycle
// while i_ready is high; depends on qpd_pkg
module qpd_outbuf
    import qpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_burst      i_burst,
    output logic        o_can_load,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_run,
    output logic        o_stream_end
);

    logic [1:0]                 r_cnt;
    logic [1:0]                 r_idx;
    logic [MAX_RES-1:0][7:0]    r_data;
    logic                       r_bare;
    logic                       r_send;
    logic                       pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    // free now, or the last word leaves this cycle
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load && (i_burst.cnt != 2'd0)) begin
            r_cnt <= i_burst.cnt;
            r_idx <= 2'd0;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && (i_burst.cnt != 2'd0)) begin
            r_data <= i_burst.data;
            r_bare <= i_burst.bare;
            r_send <= i_burst.send;
        end
    end

    assign o_out_byte    = r_bare ? 8'd0 : r_data[r_idx];
    assign o_byte_valid  = !r_bare;
    assign o_last_of_run = (r_cnt == 2'd1);
    assign o_stream_end  = r_send && (r_cnt == 2'd1);

endmodule

// ===== rtl/quoted_printable_byte_decoder.sv =====
`timescale 1ns / 1ps
// quoted_printable_byte_decoder: top level of the quoted-printable byte decoder
// depends on qpd_pkg, qpd_decode, qpd_outbuf
//
// usage
// - input channel: i_valid / o_ready carry one encoded byte (i_data_byte) and
//   i_end_mark, set on the last byte of a stream
// - output channel: o_valid / i_ready carry decoded words; o_byte_valid is low
//   only for a bare end marker, o_last_of_run marks the final word caused by
//   one input byte, o_stream_end the final word of the stream
// - plain bytes pass through, "=XY" gives the encoded byte, "==" gives '=',
//   "=" LF and "=" CR LF are soft line breaks and give nothing
// - output timing: the first word of an input byte is registered and shows on
//   the output in the cycle after the byte is taken
// - throughput: one input byte per cycle while each byte gives at most one
//   word and the receiver is ready; a byte that gives two or three words holds
//   the input until its words drain, one word a cycle while i_ready is high
// - stall: while the receiver holds i_ready low the words stay put and the
//   input is taken only once the buffer is empty
// - reset (synchronous, active low) clears the escape state and the buffer
module quoted_printable_byte_decoder
    import qpd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_mark,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last_of_run,
    output logic        o_stream_end
);

    t_burst burst;
    logic   can_load;
    logic   accept;

    // take a byte when the result register is free or frees this cycle
    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    // escape state machine and per-byte decode
    qpd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_end_mark  (i_end_mark),
        .o_burst     (burst)
    );

    // result register, up to three words per input byte
    qpd_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_burst       (burst),
        .o_can_load    (can_load),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run),
        .o_stream_end  (o_stream_end)
    );

endmodule

// ===== dv/quoted_printable_byte_decoder_tb.sv =====
`timescale 1ns / 1ps
// quoted_printable_byte_decoder_tb: self-checking bench for the quoted-printable
// byte decoder; drives encoded words, predicts decoded words; needs qpd_pkg and the rtl
module quoted_printable_byte_decoder_tb;
    import qpd_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int RST_CYCLES = 7;
    localparam int N_RANDOM   = 380;
    localparam int IDLE_PCT   = 22;
    localparam int HOLD_AT    = 150;     // input words taken before the long receiver stall
    localparam int HOLD_LEN   = 60;
    localparam int QUIET_LO   = 200;     // window of input words with no random idling
    localparam int QUIET_HI   = 280;
    localparam int TAIL       = 20;
    localparam int LIMIT      = 100000;

    // one encoded input word; drain makes the driver wait for all results first
    typedef struct packed {
        logic [7:0] data;
        logic       endm;
        logic       drain;
    } t_enc_item;

    // one decoded output word
    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic       run_last;
        logic       strm_end;
    } t_qp_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_end_mark = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_last_of_run;
    logic       o_stream_end;

    t_enc_item  enc_queue[$];       // encoded words still to be sent
    t_qp_word   decoded_due[$];     // decoded words the block still owes us

    // decoder state as we expect it to be
    t_mode      esc_mode;
    logic [3:0] esc_nibble;

    int n_taken     = 0;    // input words accepted, nonblocking
    int n_checked   = 0;    // output words compared, nonblocking
    int n_predicted = 0;    // output words predicted, written by the driver only
    int n_errors    = 0;
    int n_cycles    = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    quoted_printable_byte_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_end_mark    (i_end_mark),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_last_of_run (o_last_of_run),
        .o_stream_end  (o_stream_end)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // value of a hex digit in either case, -1 for anything else
    function automatic int hex_of(input logic [7:0] c);
        int v;
        v = -1;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = int'(c) - 'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = int'(c) - 'h41 + 10;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = int'(c) - 'h61 + 10;
        end
        return v;
    endfunction

    function automatic t_qp_word data_word(input logic [7:0] b);
        t_qp_word w;
        w = '{data: b, has_data: 1'b1, run_last: 1'b0, strm_end: 1'b0};
        return w;
    endfunction

    // decode one accepted word and queue the words it must produce
    task automatic decode_step(input logic [7:0] b, input logic endm);
        t_qp_word run[$];
        int       h;
        case (esc_mode)
            MODE_PLAIN: begin
                if (b == CH_EQ) begin
                    esc_mode = MODE_EQ;
                end else begin
                    run.push_back(data_word(b));
                end
            end
            MODE_EQ: begin
                esc_mode = MODE_PLAIN;
                h = hex_of(b);
                if (b == CH_LF) begin
                    // soft line break, nothing comes out
                end else if (b == CH_CR) begin
                    esc_mode = MODE_EQCR;
                end else if (b == CH_EQ) begin
                    run.push_back(data_word(CH_EQ));
                end else if (h >= 0) begin
                    esc_nibble = h[3:0];
                    esc_mode   = MODE_HEX1;
                end else begin
                    // stray '=' goes out as is, the byte after it too
                    run.push_back(data_word(CH_EQ));
                    run.push_back(data_word(b));
                end
            end
            MODE_HEX1: begin
                esc_mode = MODE_PLAIN;
                h = hex_of(b);
                // a bad second digit is swallowed, the lone digit goes out
                if (h >= 0) begin
                    run.push_back(data_word({esc_nibble, h[3:0]}));
                end else begin
                    run.push_back(data_word({4'h0, esc_nibble}));
                end
                esc_nibble = 4'h0;
            end
            default: begin
                esc_mode = MODE_PLAIN;
                if (b != CH_LF) begin
                    // '=' CR without LF: both come out, then the byte is plain
                    run.push_back(data_word(CH_EQ));
                    run.push_back(data_word(CH_CR));
                    if (b == CH_EQ) begin
                        esc_mode = MODE_EQ;
                    end else begin
                        run.push_back(data_word(b));
                    end
                end
            end
        endcase

        if (endm) begin
            // end of stream flushes whatever escape is half done
            case (esc_mode)
                MODE_EQ:   run.push_back(data_word(CH_EQ));
                MODE_HEX1: run.push_back(data_word({4'h0, esc_nibble}));
                MODE_EQCR: begin
                    run.push_back(data_word(CH_EQ));
                    run.push_back(data_word(CH_CR));
                end
                default: ;
            endcase
            esc_mode   = MODE_PLAIN;
            esc_nibble = 4'h0;
            if (run.size() == 0) begin
                run.push_back('{data: 8'h00, has_data: 1'b0, run_last: 1'b0, strm_end: 1'b0});
            end
            run[run.size()-1].strm_end = 1'b1;
        end

        if (run.size() > 0) begin
            run[run.size()-1].run_last = 1'b1;
        end
        foreach (run[i]) begin
            decoded_due.push_back(run[i]);
        end
        n_predicted += run.size();
    endtask

    task automatic report(input string what, input int got_v, input int exp_v);
        $display("[%0t] mismatch in %s: got %02h, expected %02h", $time, what, got_v, exp_v);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic put_enc(input logic [7:0] b, input logic e);
        enc_queue.push_back('{data: b, endm: e, drain: 1'b0});
    endtask

    // random words end a stream now and then, mid-escape included
    task automatic put_rnd(input logic [7:0] b);
        put_enc(b, $urandom_range(0, 14) == 0);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + n;
        end else begin
            c = (lower ? 8'h61 : 8'h41) + n - 8'd10;
        end
        return c;
    endfunction

    // random bytes and well-formed escapes with random content, some broken ones
    task automatic put_random_token();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            put_rnd(8'($urandom_range(0, 255)));
        end else if (sel < 65) begin
            put_rnd(CH_EQ);
            put_rnd(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            put_rnd(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end else if (sel < 72) begin
            put_rnd(CH_EQ);
            put_rnd(CH_EQ);
        end else if (sel < 78) begin
            put_rnd(CH_EQ);
            put_rnd(CH_LF);
        end else if (sel < 84) begin
            put_rnd(CH_EQ);
            put_rnd(CH_CR);
            put_rnd(CH_LF);
        end else if (sel < 89) begin
            put_rnd(CH_EQ);
            put_rnd(8'($urandom_range(0, 255)));
        end else if (sel < 94) begin
            put_rnd(CH_EQ);
            put_rnd(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
            put_rnd(8'($urandom_range(0, 255)));
        end else begin
            put_rnd(CH_EQ);
            put_rnd(CH_CR);
            put_rnd(8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------
    // driver: feeds encoded words from the queue, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv_p
        t_enc_item item;
        logic      quiet;
        logic      send;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_data_byte <= 8'h00;
            i_end_mark  <= 1'b0;
            esc_mode    = MODE_PLAIN;
            esc_nibble  = 4'h0;
        end else begin
            if (i_valid && o_ready) begin
                decode_step(i_data_byte, i_end_mark);
                n_taken <= n_taken + 1;
            end
            // slot is free when nothing was offered or the offer was just taken
            if (!i_valid || o_ready) begin
                quiet = (n_taken >= QUIET_LO) && (n_taken < QUIET_HI);
                send  = (enc_queue.size() > 0)
                        && (quiet || $urandom_range(0, 99) >= IDLE_PCT);
                // a drain word waits until every owed word has come back
                if (send && enc_queue[0].drain && (n_predicted != n_checked)) begin
                    send = 1'b0;
                end
                if (send) begin
                    item = enc_queue.pop_front();
                    i_data_byte <= item.data;
                    i_end_mark  <= item.endm;
                end
                i_valid <= send;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: drives the receiver ready and checks every decoded word
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon_p
        t_qp_word got;
        t_qp_word exp_w;
        logic     quiet;
        int       hold_left;
        logic     hold_done;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{data: o_out_byte, has_data: o_byte_valid,
                        run_last: o_last_of_run, strm_end: o_stream_end};
                if (decoded_due.size() == 0) begin
                    report("unexpected word", got.data, 0);
                end else begin
                    exp_w = decoded_due.pop_front();
                    n_checked <= n_checked + 1;
                    if (got.data !== exp_w.data)
                        report("out_byte", got.data, exp_w.data);
                    if (got.has_data !== exp_w.has_data)
                        report("byte_valid", got.has_data, exp_w.has_data);
                    if (got.run_last !== exp_w.run_last)
                        report("last_of_run", got.run_last, exp_w.run_last);
                    if (got.strm_end !== exp_w.strm_end)
                        report("stream_end", got.strm_end, exp_w.strm_end);
                end
            end
            // one long stall while the sender keeps offering, so the input backs up
            if (!hold_done && n_taken >= HOLD_AT) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            quiet = (n_taken >= QUIET_LO) && (n_taken < QUIET_HI);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial begin : main_p
        t_enc_item tmp;
        int        n_directed;
        i_rst_n     = 1'b0;

        // directed: field extremes, each escape form and every flush case
        put_enc(8'h00, 1'b0);
        put_enc(8'hFF, 1'b1);               // plain byte closing a stream
        put_enc(CH_EQ, 1'b0);               // "=41" pair of decimal digits
        put_enc(8'h34, 1'b0);
        put_enc(8'h31, 1'b0);
        put_enc(CH_EQ, 1'b0);               // "=fF" mixed case
        put_enc(8'h66, 1'b0);
        put_enc(8'h46, 1'b0);
        put_enc(CH_EQ, 1'b0);               // "==" gives '='
        put_enc(CH_EQ, 1'b0);
        put_enc(CH_EQ, 1'b0);               // soft break with CR LF
        put_enc(CH_CR, 1'b0);
        put_enc(CH_LF, 1'b0);
        put_enc(CH_EQ, 1'b0);               // '=' before a non-hex byte
        put_enc(8'h47, 1'b0);
        put_enc(CH_EQ, 1'b0);               // bad second digit is swallowed
        put_enc(8'h34, 1'b0);
        put_enc(8'h5A, 1'b0);
        put_enc(CH_EQ, 1'b0);               // '=' CR then '=', end flushes the new '='
        put_enc(CH_CR, 1'b0);
        put_enc(CH_EQ, 1'b1);
        put_enc(CH_EQ, 1'b0);               // end after one hex digit
        put_enc(8'h41, 1'b1);
        put_enc(CH_EQ, 1'b0);               // end after '=' CR
        put_enc(CH_CR, 1'b1);
        put_enc(CH_EQ, 1'b0);               // soft break at the end: bare marker
        put_enc(CH_LF, 1'b1);
        n_directed = enc_queue.size();

        while (enc_queue.size() < n_directed + N_RANDOM) begin
            put_random_token();
        end
        // sender pauses for a full drain at the start of random traffic and mid-way
        tmp = enc_queue[n_directed];
        tmp.drain = 1'b1;
        enc_queue[n_directed] = tmp;
        tmp = enc_queue[n_directed + 240];
        tmp.drain = 1'b1;
        enc_queue[n_directed + 240] = tmp;

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sample between edges so nothing races the clocked processes
        while (enc_queue.size() != 0 || i_valid || n_checked != n_predicted) begin
            @(negedge i_clk);
        end
        repeat (TAIL) @(posedge i_clk);
        @(negedge i_clk);
        if (decoded_due.size() != 0) begin
            report("words never delivered", decoded_due.size(), 0);
        end

        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qpd_pkg.sv
rtl/qpd_decode.sv
rtl/qpd_outbuf.sv
rtl/quoted_printable_byte_decoder.sv
dv/quoted_printable_byte_decoder_tb.sv
